// ----- rtl/subset_instruction_execute_unit_macros.svh -----
// ----------------------------------------------------------------------------
// subset_instruction_execute_unit_macros.svh
// Assertion macros shared by the execute unit. Each macro expects clk and
// rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef SUBSET_INSTRUCTION_EXECUTE_UNIT_MACROS_SVH
`define SUBSET_INSTRUCTION_EXECUTE_UNIT_MACROS_SVH

// Check a same-cycle implication.
`define SIE_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("execute unit: same-cycle check failed");

// Check an implication in the following cycle.
`define SIE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("execute unit: next-cycle check failed");

`endif

// ----- rtl/sie_pkg.sv -----
// ----------------------------------------------------------------------------
// sie_pkg
// Types and constants of the subset instruction execute unit.
// ----------------------------------------------------------------------------
package sie_pkg;

    localparam int NUM_REGS = 16;

    typedef logic [3:0]  reg_idx_t;
    typedef logic [7:0]  byte_t;
    typedef logic [11:0] addr_t;

    localparam addr_t PC_RESET  = 12'd512;
    localparam addr_t SKIP_STEP = 12'h002;

    // Decoded instruction codes; codes 12 to 15 do nothing
    typedef enum logic [3:0] {
        OP_RET         = 4'd0,
        OP_JUMP        = 4'd1,
        OP_CALL        = 4'd2,
        OP_SKIP_EQ_K   = 4'd3,
        OP_SKIP_NE_K   = 4'd4,
        OP_SKIP_EQ_REG = 4'd5,
        OP_LOAD_K      = 4'd6,
        OP_ADD_K       = 4'd7,
        OP_MOVE        = 4'd8,
        OP_AND         = 4'd9,
        OP_OR          = 4'd10,
        OP_XOR         = 4'd11
    } op_t;

    // Execute stage result, from the ALU to the pipeline control
    typedef struct packed {
        addr_t pc_next;
        byte_t vx_out;
        logic  reg_we;
        logic  push;
        logic  skipped;
    } exec_res_t;

endpackage

// ----- rtl/sie_cmd_if.sv -----
// ----------------------------------------------------------------------------
// sie_cmd_if
// Instruction channel: one decoded instruction per item.
// ----------------------------------------------------------------------------
interface sie_cmd_if import sie_pkg::*; ();

    logic     valid;
    logic     ready;
    logic [3:0] op;
    addr_t    address;
    byte_t    constant;
    reg_idx_t reg_x;
    reg_idx_t reg_y;

    modport source (
        output valid,
        output op,
        output address,
        output constant,
        output reg_x,
        output reg_y,
        input  ready
    );

    modport sink (
        input  valid,
        input  op,
        input  address,
        input  constant,
        input  reg_x,
        input  reg_y,
        output ready
    );

endinterface

// ----- rtl/sie_rsp_if.sv -----
// ----------------------------------------------------------------------------
// sie_rsp_if
// Result channel: machine state after each executed instruction.
// ----------------------------------------------------------------------------
interface sie_rsp_if import sie_pkg::*; ();

    logic       valid;
    logic       ready;
    addr_t      program_counter;
    byte_t      vx_value;
    logic       skipped;
    logic [4:0] stack_depth;
    logic       stack_error;

    modport source (
        output valid,
        output program_counter,
        output vx_value,
        output skipped,
        output stack_depth,
        output stack_error,
        input  ready
    );

    modport sink (
        input  valid,
        input  program_counter,
        input  vx_value,
        input  skipped,
        input  stack_depth,
        input  stack_error,
        output ready
    );

endinterface

// ----- rtl/sie_regfile.sv -----
// ----------------------------------------------------------------------------
// sie_regfile
// Sixteen 8-bit general registers: two registered read ports, one write
// port, per-entry valid bits for the zero reset, write-to-read bypass.
// ----------------------------------------------------------------------------
module sie_regfile import sie_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     rd_en,
    input  reg_idx_t rd_addr_x,
    input  reg_idx_t rd_addr_y,
    input  logic     we,
    input  reg_idx_t waddr,
    input  byte_t    wdata,
    output byte_t    rd_x,
    output byte_t    rd_y
);

    byte_t                 vreg_mem [NUM_REGS];
    logic [NUM_REGS-1:0]   valid_reg;
    byte_t                 mem_x_reg;
    byte_t                 mem_y_reg;
    byte_t                 fwd_data_reg;
    logic                  vld_x_reg;
    logic                  vld_y_reg;
    logic                  fwd_x_reg;
    logic                  fwd_y_reg;

    // Write the array, read both ports on a new item
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            vreg_mem[waddr] <= wdata;
        end
        if (rd_en)
        begin
            mem_x_reg    <= vreg_mem[rd_addr_x];
            mem_y_reg    <= vreg_mem[rd_addr_y];
            fwd_data_reg <= wdata;
        end
    end

    // Track written entries and catch a write landing on a read address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            vld_x_reg <= 1'b0;
            vld_y_reg <= 1'b0;
            fwd_x_reg <= 1'b0;
            fwd_y_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            if (rd_en)
            begin
                vld_x_reg <= valid_reg[rd_addr_x];
                vld_y_reg <= valid_reg[rd_addr_y];
                fwd_x_reg <= we && (waddr == rd_addr_x);
                fwd_y_reg <= we && (waddr == rd_addr_y);
            end
        end
    end

    // Select bypass data, stored data or the reset value
    assign rd_x = fwd_x_reg ? fwd_data_reg : (vld_x_reg ? mem_x_reg : '0);
    assign rd_y = fwd_y_reg ? fwd_data_reg : (vld_y_reg ? mem_y_reg : '0);

endmodule

// ----- rtl/sie_stack.sv -----
// ----------------------------------------------------------------------------
// sie_stack
// Return address memory: one registered read port, one write port and a
// bypass for a push landing on the address being read.
// ----------------------------------------------------------------------------
module sie_stack import sie_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  addr_t                    wdata,
    output addr_t                    rdata
);

    addr_t stack_mem [DEPTH];
    addr_t mem_q_reg;
    addr_t fwd_data_reg;
    logic  fwd_reg;

    // Write on push, read on a new item
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            stack_mem[waddr] <= wdata;
        end
        if (rd_en)
        begin
            mem_q_reg    <= stack_mem[raddr];
            fwd_data_reg <= wdata;
        end
    end

    // Flag a push to the entry being read in the same cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            fwd_reg <= we && (waddr == raddr);
        end
    end

    assign rdata = fwd_reg ? fwd_data_reg : mem_q_reg;

endmodule

// ----- rtl/sie_alu.sv -----
// ----------------------------------------------------------------------------
// sie_alu
// Execute stage datapath: register operations, skip compares and the next
// program counter.
// ----------------------------------------------------------------------------
module sie_alu import sie_pkg::*; (
    input  op_t       op,
    input  addr_t     address,
    input  byte_t     constant,
    input  byte_t     vx,
    input  byte_t     vy,
    input  addr_t     pc,
    input  addr_t     stack_top,
    input  logic      stack_err,
    output exec_res_t res
);

    byte_t vx_new;
    logic  reg_we;
    logic  skip;

    // Decode register writes and skip conditions
    always_comb
    begin
        vx_new = vx;
        reg_we = 1'b0;
        skip   = 1'b0;
        unique case (op)
            OP_SKIP_EQ_K:   skip = (vx == constant);
            OP_SKIP_NE_K:   skip = (vx != constant);
            OP_SKIP_EQ_REG: skip = (vx == vy);
            OP_LOAD_K:
            begin
                vx_new = constant;
                reg_we = 1'b1;
            end
            OP_ADD_K:
            begin
                vx_new = vx + constant;
                reg_we = 1'b1;
            end
            OP_MOVE:
            begin
                vx_new = vy;
                reg_we = 1'b1;
            end
            OP_AND:
            begin
                vx_new = vx & vy;
                reg_we = 1'b1;
            end
            OP_OR:
            begin
                vx_new = vx | vy;
                reg_we = 1'b1;
            end
            OP_XOR:
            begin
                vx_new = vx ^ vy;
                reg_we = 1'b1;
            end
            default:
            begin
                vx_new = vx;
                reg_we = 1'b0;
                skip   = 1'b0;
            end
        endcase
    end

    // Pick the next program counter and pack the result
    always_comb
    begin
        res.pc_next = pc;
        res.push    = 1'b0;
        res.vx_out  = vx_new;
        res.reg_we  = reg_we;
        res.skipped = skip;
        if (op == OP_RET && !stack_err)
        begin
            res.pc_next = stack_top;
        end
        else if (op == OP_JUMP)
        begin
            res.pc_next = address;
        end
        else if (op == OP_CALL && !stack_err)
        begin
            res.pc_next = address;
            res.push    = 1'b1;
        end
        else if (skip)
        begin
            res.pc_next = pc + SKIP_STEP;
        end
    end

endmodule

// ----- rtl/subset_instruction_execute_unit.sv -----
// ----------------------------------------------------------------------------
// subset_instruction_execute_unit
// Executes one decoded instruction per item (return, jump, call, skips, load,
// add, move, AND, OR, XOR) and reports the program counter, VX, the skip
// flag, the stack depth and the stack error flag. An item can enter every
// clock cycle while results are taken; its result is loaded into the result
// register when the execute stage advances. The acceptance edge reads the
// register file and the return stack (synchronous memories); the execute
// stage then executes, and the edge on which it advances writes back and
// loads the result register. A result that is not taken stalls the input
// only once both the execute stage and the result register hold an item. The
// stack level is kept at acceptance so return reads the right entry; a write
// by the previous item to an entry being read is bypassed. No clearing pass
// is needed after reset.
// ----------------------------------------------------------------------------
module subset_instruction_execute_unit import sie_pkg::*; #(
    parameter int STACK_DEPTH = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    sie_cmd_if.sink   cmd,
    sie_rsp_if.source rsp
);

`include "subset_instruction_execute_unit_macros.svh"

    localparam int LVL_W  = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = $clog2(STACK_DEPTH);
    localparam logic [LVL_W-1:0] LVL_FULL = LVL_W'(STACK_DEPTH);

    logic [LVL_W-1:0]  level_reg;
    logic [LVL_W-1:0]  level_next;
    logic              accept;
    logic              s0_is_ret;
    logic              s0_is_call;
    logic              s0_err;
    logic              s0_push;

    logic              s1_valid_reg;
    op_t               s1_op_reg;
    addr_t             s1_address_reg;
    byte_t             s1_constant_reg;
    reg_idx_t          s1_x_reg;
    logic              s1_err_reg;
    logic [LVL_W-1:0]  s1_level_reg;
    logic [ADDR_W-1:0] s1_push_addr_reg;
    logic              s1_adv;

    addr_t             pc_reg;
    byte_t             vx_rd;
    byte_t             vy_rd;
    addr_t             stack_rd;
    exec_res_t         res;
    logic              reg_we;
    logic              stk_we;
    logic [LVL_W+4:0]  depth_ext;

    logic              out_valid_reg;
    addr_t             out_pc_reg;
    byte_t             out_vx_reg;
    logic              out_skipped_reg;
    logic [4:0]        out_depth_reg;
    logic              out_err_reg;

    // Handshake: execute stage moves when the result register frees up
    assign s1_adv     = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign cmd.ready  = !s1_valid_reg || s1_adv;
    assign accept     = cmd.valid && cmd.ready;

    // Resolve the stack level at acceptance
    assign s0_is_ret  = (cmd.op == OP_RET);
    assign s0_is_call = (cmd.op == OP_CALL);
    assign s0_err     = (s0_is_ret && (level_reg == '0)) ||
                        (s0_is_call && (level_reg == LVL_FULL));
    assign s0_push    = accept && s0_is_call && !s0_err;

    always_comb
    begin
        level_next = level_reg;
        if (accept && !s0_err)
        begin
            if (s0_is_ret)
            begin
                level_next = level_reg - LVL_W'(1);
            end
            else if (s0_is_call)
            begin
                level_next = level_reg + LVL_W'(1);
            end
        end
    end

    // State memories
    sie_regfile u_regfile (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (accept),
        .rd_addr_x (cmd.reg_x),
        .rd_addr_y (cmd.reg_y),
        .we        (reg_we),
        .waddr     (s1_x_reg),
        .wdata     (res.vx_out),
        .rd_x      (vx_rd),
        .rd_y      (vy_rd)
    );

    sie_stack #(
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .rst_n (rst_n),
        .rd_en (accept),
        .raddr (level_reg[ADDR_W-1:0] - ADDR_W'(1)),
        .we    (stk_we),
        .waddr (s1_push_addr_reg),
        .wdata (pc_reg),
        .rdata (stack_rd)
    );

    // Execute
    sie_alu u_alu (
        .op        (s1_op_reg),
        .address   (s1_address_reg),
        .constant  (s1_constant_reg),
        .vx        (vx_rd),
        .vy        (vy_rd),
        .pc        (pc_reg),
        .stack_top (stack_rd),
        .stack_err (s1_err_reg),
        .res       (res)
    );

    assign reg_we = s1_adv && res.reg_we;
    assign stk_we = s1_adv && res.push;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            pc_reg        <= PC_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            level_reg <= level_next;
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                pc_reg        <= res.pc_next;
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the item's fields for the execute stage
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg        <= op_t'(cmd.op);
            s1_address_reg   <= cmd.address;
            s1_constant_reg  <= cmd.constant;
            s1_x_reg         <= cmd.reg_x;
            s1_err_reg       <= s0_err;
            s1_level_reg     <= level_next;
            s1_push_addr_reg <= level_reg[ADDR_W-1:0];
        end
    end

    // Result register
    assign depth_ext = {5'b0, s1_level_reg};

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_pc_reg      <= res.pc_next;
            out_vx_reg      <= res.vx_out;
            out_skipped_reg <= res.skipped;
            out_depth_reg   <= depth_ext[4:0];
            out_err_reg     <= s1_err_reg;
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.program_counter = out_pc_reg;
    assign rsp.vx_value        = out_vx_reg;
    assign rsp.skipped         = out_skipped_reg;
    assign rsp.stack_depth     = out_depth_reg;
    assign rsp.stack_error     = out_err_reg;

    // Checks
    `SIE_ASSERT_NOW(a_level_bound, 1'b1, level_reg <= LVL_FULL)
    `SIE_ASSERT_NOW(a_no_push_on_error, s1_valid_reg && s1_err_reg, !stk_we)
    `SIE_ASSERT_NEXT(a_stage_holds, s1_valid_reg && out_valid_reg && !rsp.ready, s1_valid_reg)
    `SIE_ASSERT_NEXT(a_call_pushes, s0_push, level_reg == $past(level_reg) + LVL_W'(1))

endmodule
